// ===== hdl/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, constants and operation codes for the bitmap membership set.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int unsigned OP_W  = 3;
	localparam int unsigned ID_W  = 12;
	localparam int unsigned POS_W = 13;	// search positions reach 4096
	localparam int unsigned CNT_W = 13;

	localparam int unsigned MAX_IDS_DEF    = 4096;
	localparam int unsigned BLOCK_BITS_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_ERASE  = 3'd1,
		OP_CHECK  = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_NEXT   = 3'd4,
		OP_FIRST  = 3'd5
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [ID_W-1:0] entity_id;
	} req_t;

	typedef struct packed {
		logic             present;
		logic [POS_W-1:0] result_id;
		logic [CNT_W-1:0] population;
		logic             status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;	// latch a new request
		logic eval;	// RAM read data is valid, act on it
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic again;	// search goes on to the next block
	} ctl_sts_t;

endpackage

// ===== hdl/bitmap_membership_set_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_membership_set_core
// Set of ids kept as a bitmap of blocks, with population count and search.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req.operation, req.entity_id) is taken on a rising edge with
//   start high and busy low. Operations: insert, erase, check, clear,
//   next member after an id, first member.
//   Each request gives exactly one response on rsp, shown for one cycle
//   with done high. The receiver cannot hold it off; it must take it then.
// Sequencing:
//   Insert, erase, check, clear and ops 6/7 pass through the lookup and
//   evaluate states before done rises; busy drops while done is high, so a
//   new request can be taken in the response cycle.
//   Searches visit one block per lookup/evaluate pass (RAM read, then
//   evaluate), until a member is found or the allocated end is reached.
//   The single-port-read block RAM sets this sequence.
// Reset:
//   arst_n clears the allocation, count and block valid bits at once; no
//   clearing pass is needed, requests are taken the cycle after release.
// ----------------------------------------------------------------------------
module bitmap_membership_set_core #(
	parameter int unsigned MAX_IDS    = bms_pkg::MAX_IDS_DEF,
	parameter int unsigned BLOCK_BITS = bms_pkg::BLOCK_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bms_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output bms_pkg::rsp_t rsp
);

	bms_pkg::ctl_cmd_t cmd;
	bms_pkg::ctl_sts_t sts;

	// sequencer: idle -> lookup -> evaluate (-> lookup while searching) -> response
	bms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// word store, allocation/count registers, update and find-first logic
	bms_datapath #(
		.MAX_IDS    (MAX_IDS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// ===== hdl/bms_ram.sv =====
// ----------------------------------------------------------------------------
// bms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bms_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/bms_ctrl.sv =====
// ----------------------------------------------------------------------------
// bms_ctrl
// Sequencer: lookup / evaluate loop per request, one response cycle.
// ----------------------------------------------------------------------------
module bms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bms_pkg::ctl_sts_t   sts,
	output bms_pkg::ctl_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOKUP = 4'b0010,
		ST_EVAL   = 4'b0100,
		ST_RESP   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q == ST_LOOKUP) || (state_q == ST_EVAL);
	assign done   = (state_q == ST_RESP);
	assign accept = start && !busy;

	assign cmd.load = accept;
	assign cmd.eval = (state_q == ST_EVAL);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   state_d = accept ? ST_LOOKUP : ST_IDLE;
			ST_LOOKUP: state_d = ST_EVAL;
			ST_EVAL:   state_d = sts.again ? ST_LOOKUP : ST_RESP;
			ST_RESP:   state_d = accept ? ST_LOOKUP : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/bms_datapath.sv =====
// ----------------------------------------------------------------------------
// bms_datapath
// Bitmap word store, allocation and count registers, search and update logic.
// ----------------------------------------------------------------------------
module bms_datapath #(
	parameter int unsigned MAX_IDS    = bms_pkg::MAX_IDS_DEF,
	parameter int unsigned BLOCK_BITS = bms_pkg::BLOCK_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bms_pkg::req_t     req,
	input  bms_pkg::ctl_cmd_t cmd,
	output bms_pkg::ctl_sts_t sts,
	output bms_pkg::rsp_t     rsp
);

	localparam int unsigned NUM_BLOCKS = MAX_IDS / BLOCK_BITS;
	localparam int unsigned BIT_W      = $clog2(BLOCK_BITS);
	localparam int unsigned IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int unsigned ALLOC_W    = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned BLK_W      = bms_pkg::POS_W - BIT_W;

	logic [bms_pkg::OP_W-1:0]  op_q;
	logic [bms_pkg::POS_W-1:0] pos_q;
	logic [ALLOC_W-1:0]        alloc_q;
	logic [bms_pkg::CNT_W-1:0] count_q;
	logic [NUM_BLOCKS-1:0]     valid_q;
	bms_pkg::rsp_t             rsp_q;

	logic [BLK_W-1:0]      blk;
	logic [IDX_W-1:0]      addr;
	logic [BIT_W-1:0]      off;
	logic [BLOCK_BITS-1:0] rdata, word, bitmask, masked, lowest, wdata;
	logic [BIT_W-1:0]      ffs;
	logic [31:0]           blk32, next_blk32, end32;
	logic                  in_cap, in_alloc, hit, we, start_past_end, more;

	// result and next-state signals
	logic                      again;
	logic                      finish;
	bms_pkg::rsp_t             rsp_d;
	logic [ALLOC_W-1:0]        alloc_d;
	logic [bms_pkg::CNT_W-1:0] count_d;
	logic                      set_valid, clr_all;

	assign blk  = pos_q[bms_pkg::POS_W-1:BIT_W];
	assign off  = pos_q[BIT_W-1:0];
	assign addr = IDX_W'(blk);

	bms_ram #(
		.WIDTH (BLOCK_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	// lowest set bit of the masked word
	always_comb begin
		lowest = masked & (~masked + BLOCK_BITS'(1));
		ffs    = '0;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			if (lowest[i]) begin
				ffs = ffs | BIT_W'(i);
			end
		end
	end

	always_comb begin
		blk32          = 32'(blk);
		next_blk32     = blk32 + 32'd1;
		end32          = 32'(alloc_q) << BIT_W;
		in_cap         = blk32 < 32'(NUM_BLOCKS);
		in_alloc       = blk32 < 32'(alloc_q);
		word           = valid_q[addr] ? rdata : '0;	// never-written block reads empty
		bitmask        = BLOCK_BITS'(1) << off;
		hit            = (word & bitmask) != '0;
		masked         = word & ({BLOCK_BITS{1'b1}} << off);
		start_past_end = 32'(pos_q) >= end32;
		more           = next_blk32 < 32'(alloc_q);

		rsp_d      = '0;
		alloc_d    = alloc_q;
		count_d    = count_q;
		we         = 1'b0;
		wdata      = word;
		set_valid  = 1'b0;
		clr_all    = 1'b0;
		again      = 1'b0;

		case (bms_pkg::op_t'(op_q))
			bms_pkg::OP_INSERT: begin
				if (!in_cap) begin
					rsp_d.status = 1'b1;
				end else begin
					if (!in_alloc) begin
						alloc_d = ALLOC_W'(next_blk32);
					end
					if (!hit) begin
						we        = 1'b1;
						wdata     = word | bitmask;
						set_valid = 1'b1;
						count_d   = count_q + bms_pkg::CNT_W'(1);
					end
				end
			end
			bms_pkg::OP_ERASE: begin
				if (in_alloc && hit) begin
					we      = 1'b1;
					wdata   = word & ~bitmask;
					count_d = count_q - bms_pkg::CNT_W'(1);
				end
			end
			bms_pkg::OP_CHECK: begin
				rsp_d.present = in_alloc && hit;
			end
			bms_pkg::OP_CLEAR: begin
				clr_all = 1'b1;
				alloc_d = '0;
				count_d = '0;
			end
			bms_pkg::OP_NEXT, bms_pkg::OP_FIRST: begin
				rsp_d.result_id = bms_pkg::POS_W'(end32);
				if (!start_past_end) begin
					if (masked != '0) begin
						rsp_d.present   = 1'b1;
						rsp_d.result_id = bms_pkg::POS_W'((blk32 << BIT_W) | 32'(ffs));
					end else if (more) begin
						again = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// the word store only changes in the evaluate cycle
		we = we && cmd.eval;

		rsp_d.population = count_d;
		finish = cmd.eval && !again;
	end

	assign sts.again = cmd.eval && again;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			count_q <= '0;
			valid_q <= '0;
		end else if (cmd.eval) begin
			alloc_q <= alloc_d;
			count_q <= count_d;
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			case (bms_pkg::op_t'(req.operation))
				bms_pkg::OP_NEXT:  pos_q <= bms_pkg::POS_W'(req.entity_id) + bms_pkg::POS_W'(1);
				bms_pkg::OP_FIRST: pos_q <= '0;
				default:           pos_q <= bms_pkg::POS_W'(req.entity_id);
			endcase
		end else if (sts.again) begin
			pos_q <= bms_pkg::POS_W'(next_blk32 << BIT_W);
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== hdl/bms_checker.sv =====
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks of the request/response sequencing.
// ----------------------------------------------------------------------------
module bms_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input bms_pkg::rsp_t rsp
);

	// response cycle never overlaps work
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// every end of work shows exactly one response
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("work ended without a response");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response held longer than one cycle");

	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.population <= 13'd4096))
		else $error("population out of range");

endmodule

bind bitmap_membership_set_core bms_checker u_bms_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ===== sim/tb_bitmap_membership_set_core.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_membership_set_core
// Self-checking bench for the bitmap membership set core.
// ----------------------------------------------------------------------------
// A shadow copy of the bitmap, its allocated block count and its population
// predicts every response when a request is taken. A monitor compares each
// done-strobed response field by field with the oldest prediction. Stimulus
// is a directed corner list, then member walks (fill a region, then first
// and a next-chain to the end), then random mixed traffic with random start
// gaps, and last a back-to-back burst with no gaps at all.
// ----------------------------------------------------------------------------
module tb_bitmap_membership_set_core;

	timeunit 1ns;
	timeprecision 1ps;

	import bms_pkg::*;

	localparam int unsigned NUM_BLOCKS   = MAX_IDS_DEF / BLOCK_BITS_DEF;
	// unused opcodes: the core must answer with population only
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	// drain margin covers the longest request, a full search over every block
	localparam int unsigned DRAIN_CYCLES = 2 * NUM_BLOCKS + 16;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct {
		req_t cmd;
		rsp_t want;
	} pending_t;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	req_t  req    = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	// shadow state of the set
	bit [BLOCK_BITS_DEF-1:0] shadow_words [NUM_BLOCKS];
	int unsigned shadow_blocks  = 0;
	int unsigned shadow_members = 0;

	pending_t    pending_rsp [$];
	rsp_t        last_predicted;
	int unsigned err_count   = 0;
	bit          idle_enable = 1'b1;

	bitmap_membership_set_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: applies one request to the shadow set, returns response
	// ------------------------------------------------------------------
	function automatic rsp_t predict_set_op(req_t r);
		rsp_t        o;
		int unsigned blk;
		int unsigned bitpos;
		int unsigned pos;
		int unsigned end_pos;
		bit          found;
		o      = '0;
		blk    = r.entity_id / BLOCK_BITS_DEF;
		bitpos = r.entity_id % BLOCK_BITS_DEF;
		case (r.operation)
		OP_INSERT: begin
			if (blk >= NUM_BLOCKS) begin
				o.status = 1'b1;
			end else begin
				// grow allocation up to the id's block, new blocks zeroed
				while (shadow_blocks <= blk) begin
					shadow_words[shadow_blocks] = '0;
					shadow_blocks++;
				end
				if (!shadow_words[blk][bitpos]) begin
					shadow_words[blk][bitpos] = 1'b1;
					shadow_members++;
				end
			end
		end
		OP_ERASE: begin
			if (blk < shadow_blocks && shadow_words[blk][bitpos]) begin
				shadow_words[blk][bitpos] = 1'b0;
				shadow_members--;
			end
		end
		OP_CHECK: begin
			o.present = (blk < shadow_blocks) && shadow_words[blk][bitpos];
		end
		OP_CLEAR: begin
			shadow_blocks  = 0;
			shadow_members = 0;
		end
		OP_NEXT, OP_FIRST: begin
			// next excludes the start id; first starts at zero
			pos     = (r.operation == OP_NEXT) ? int'(r.entity_id) + 1 : 0;
			end_pos = shadow_blocks * BLOCK_BITS_DEF;
			found   = 1'b0;
			while (pos < end_pos && !found) begin
				if (shadow_words[pos / BLOCK_BITS_DEF][pos % BLOCK_BITS_DEF])
					found = 1'b1;
				else
					pos++;
			end
			o.present   = found;
			o.result_id = found ? pos[POS_W-1:0] : end_pos[POS_W-1:0];
		end
		default: begin
		end
		endcase
		o.population = shadow_members[CNT_W-1:0];
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Send one request: hold start until taken (start high, busy low at
	// the edge), record the prediction, then maybe drop start for a gap.
	// start is only lowered when a gap follows, so it never gets two
	// assignments in one step.
	// ------------------------------------------------------------------
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		req_t     r;
		pending_t p;
		r.operation = op;
		r.entity_id = id;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		last_predicted = predict_set_op(r);
		p.cmd  = r;
		p.want = last_predicted;
		pending_rsp.push_back(p);
		if (idle_enable && $urandom_range(99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// mostly low ids so members collide; sometimes anywhere
	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 85)
			return ID_W'($urandom_range(0, 511));
		return ID_W'($urandom_range(0, MAX_IDS_DEF - 1));
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int unsigned w;
		w = $urandom_range(99);
		if (w < 30) return OP_INSERT;
		if (w < 45) return OP_ERASE;
		if (w < 63) return OP_CHECK;
		if (w < 66) return OP_CLEAR;
		if (w < 84) return OP_NEXT;
		if (w < 94) return OP_FIRST;
		if (w < 97) return OP_SPARE6;
		return OP_SPARE7;
	endfunction

	// ------------------------------------------------------------------
	// Response checker: every done cycle pops the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pending_t p;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("ERROR: unexpected response present=%0b id=%0d pop=%0d st=%0b",
						rsp.present, rsp.result_id, rsp.population, rsp.status);
			end else begin
				p = pending_rsp.pop_front();
				if (rsp.present !== p.want.present || rsp.result_id !== p.want.result_id ||
						rsp.population !== p.want.population ||
						rsp.status !== p.want.status) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$write("ERROR: op=%0d id=%0d expected present=%0b id=%0d pop=%0d st=%0b",
							p.cmd.operation, p.cmd.entity_id,
							p.want.present, p.want.result_id, p.want.population,
							p.want.status);
						$display(", got present=%0b id=%0d pop=%0d st=%0b",
							rsp.present, rsp.result_id, rsp.population, rsp.status);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corners: empty set, lowest/highest ids, repeated insert and erase,
	// searches off the allocated end, clear, spare opcodes.
	task automatic test_directed_corners();
		send_request(OP_FIRST,  12'd0);		// nothing allocated
		send_request(OP_NEXT,   12'd0);
		send_request(OP_CHECK,  12'd0);
		send_request(OP_ERASE,  12'd5);		// beyond allocation
		send_request(OP_INSERT, 12'd0);
		send_request(OP_INSERT, 12'hFFF);	// allocates every block
		send_request(OP_INSERT, 12'hFFF);	// already a member
		send_request(OP_CHECK,  12'hFFF);
		send_request(OP_CHECK,  12'd1);
		send_request(OP_NEXT,   12'd0);		// full-length search
		send_request(OP_NEXT,   12'hFFF);	// start past the end
		send_request(OP_FIRST,  12'd0);		// member at position zero
		send_request(OP_ERASE,  12'd0);
		send_request(OP_ERASE,  12'd0);		// no longer a member
		send_request(OP_FIRST,  12'd0);
		send_request(OP_SPARE6, 12'd77);
		send_request(OP_SPARE7, 12'hFFF);
		send_request(OP_CLEAR,  12'd0);
		send_request(OP_CHECK,  12'hFFF);	// freed block
		send_request(OP_NEXT,   12'd0);
		send_request(OP_INSERT, 12'd100);
		send_request(OP_NEXT,   12'd127);	// last allocated position
		send_request(OP_ERASE,  12'd200);
		send_request(OP_INSERT, 12'd63);
		send_request(OP_NEXT,   12'd62);
		send_request(OP_FIRST,  12'd0);
	endtask

	// Fill a 256-id window, then walk the set with first and a chain of next.
	task automatic test_search_walks(input int unsigned rounds);
		logic [ID_W-1:0] base;
		int unsigned     fill;
		for (int unsigned n = 0; n < rounds; n++) begin
			if ($urandom_range(99) < 70)
				send_request(OP_CLEAR, pick_id());
			base = pick_id() & 12'hF00;
			fill = $urandom_range(2, 10);
			for (int unsigned k = 0; k < fill; k++)
				send_request(OP_INSERT, base + ID_W'($urandom_range(0, 255)));
			if ($urandom_range(1))
				send_request(OP_ERASE, base + ID_W'($urandom_range(0, 255)));
			send_request(OP_CHECK, base + ID_W'($urandom_range(0, 255)));
			send_request(OP_FIRST, pick_id());
			while (last_predicted.present)
				send_request(OP_NEXT, last_predicted.result_id[ID_W-1:0]);
		end
	endtask

	task automatic test_random_ops(input int unsigned count);
		for (int unsigned n = 0; n < count; n++)
			send_request(pick_op(), pick_id());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_search_walks(14);
		test_random_ops(300);
		// long stretch with start never dropped
		idle_enable = 1'b0;
		test_random_ops(150);

		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
